/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is applied
`define PIPQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every rising edge, reset included
`define PIPQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/pipq_pkg.sv */
`timescale 1ns / 1ps

package pipq_pkg;

  localparam int IRQ_COUNT     = 32;
  localparam int PRIORITY_BITS = 4;

  localparam int IrqNumW  = 5;
  localparam int CountW   = 6;
  localparam int ActionW  = 2;
  localparam int TableW   = 64;
  localparam int AddrW    = 4;
  localparam int IrqIdxW  = (IRQ_COUNT > 1) ? $clog2(IRQ_COUNT) : 1;
  localparam int LenW     = $clog2(IRQ_COUNT + 1);

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [IrqNumW-1:0] irq_number;
  } in_item_t;

  typedef struct packed {
    logic               popped_valid;
    logic [IrqNumW-1:0] popped_irq;
    logic [CountW-1:0]  pending_count;
  } result_t;

  typedef struct packed {
    logic [TableW-1:0] table_low;
    logic [TableW-1:0] table_high;
  } prio_tables_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // register indexes, decoded from paddr[3]
  localparam logic REG_TABLE_LOW  = 1'b0;
  localparam logic REG_TABLE_HIGH = 1'b1;

  function automatic logic [PRIORITY_BITS-1:0] prio_of(input prio_tables_t tables,
                                                       input logic [IrqNumW-1:0] v);
    logic [TableW-1:0] sel;
    sel = v[4] ? tables.table_high : tables.table_low;
    return sel[{v[3:0], 2'b00} +: PRIORITY_BITS];
  endfunction

endpackage

/* rtl/core/pipq_cfg.sv */
`timescale 1ns / 1ps

module pipq_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pipq_pkg::AddrW-1:0]  paddr,
  input  logic [pipq_pkg::TableW-1:0] pwdata,
  output logic [pipq_pkg::TableW-1:0] prdata,
  output logic                       pready,
  output pipq_pkg::prio_tables_t     tables_o
);

  logic [pipq_pkg::TableW-1:0] low_q, low_d;
  logic [pipq_pkg::TableW-1:0] high_q, high_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (wr_en) begin
      case (paddr[3])
        pipq_pkg::REG_TABLE_LOW:  low_d  = pwdata;
        pipq_pkg::REG_TABLE_HIGH: high_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign prdata              = (paddr[3] == pipq_pkg::REG_TABLE_HIGH) ? high_q : low_q;
  assign tables_o.table_low  = low_q;
  assign tables_o.table_high = high_q;

endmodule

/* rtl/core/pipq_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pipq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output pipq_pkg::dp_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_d     = (state_q == ST_EXEC);
  assign busy_o     = (state_q == ST_EXEC);
  assign done_o     = done_q;
  assign cmd_o.load = start_i && (state_q == ST_IDLE);
  assign cmd_o.exec = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  `PIPQ_ASSERT(a_start_runs, clk_i, rst_ni, (start_i && !busy_o) |=> (busy_o && !done_o), "transfer did not start the execute step")
  `PIPQ_ASSERT(a_exec_strobes, clk_i, rst_ni, busy_o |=> (done_o && !busy_o), "execute step gave no result strobe")

endmodule

/* rtl/core/pipq_dp.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pipq_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pipq_pkg::dp_cmd_t      cmd_i,
  input  pipq_pkg::in_item_t     item_i,
  input  pipq_pkg::prio_tables_t tables_i,
  output pipq_pkg::result_t      result_o
);

  localparam int N = pipq_pkg::IRQ_COUNT;

  // prefix or: bit i is set when any bit at or below i is set
  function automatic logic [N-1:0] prefix_or(input logic [N-1:0] x);
    logic [N-1:0] r;
    r = x;
    for (int s = 1; s < N; s = s * 2) begin
      r = r | (r << s);
    end
    return r;
  endfunction

  pipq_pkg::in_item_t op_q;
  pipq_pkg::result_t  res_q, res_d;

  logic [pipq_pkg::IrqIdxW-1:0] order_q [N];
  logic [pipq_pkg::IrqIdxW-1:0] order_d [N];
  logic [pipq_pkg::IrqIdxW-1:0] prev_e  [N];
  logic [pipq_pkg::IrqIdxW-1:0] next_e  [N];
  logic [pipq_pkg::LenW-1:0]    len_q, len_d;
  logic [N-1:0]                 bits_q, bits_d;

  logic [N-1:0] cell_valid, cell_ge, cell_match;
  logic [N-1:0] ins_mask, ins_after, ins_at, rem_mask;
  logic [pipq_pkg::PRIORITY_BITS-1:0] new_prio;
  logic [pipq_pkg::IrqIdxW-1:0]       v_idx;
  logic                               irq_ok, is_pending, do_push, do_pop, do_clear;
  logic                               do_down;
  logic [N-1:0]                       down_mask;

  assign v_idx      = op_q.irq_number[pipq_pkg::IrqIdxW-1:0];
  assign irq_ok     = (32'(op_q.irq_number) < N);
  assign is_pending = bits_q[v_idx];
  assign new_prio   = pipq_pkg::prio_of(tables_i, op_q.irq_number);

  // compare cells along the list
  for (genvar g = 0; g < N; g++) begin : g_cell
    assign cell_valid[g] = (len_q > pipq_pkg::LenW'(g));
    assign cell_ge[g]    = !cell_valid[g] ||
                           (pipq_pkg::prio_of(tables_i, pipq_pkg::IrqNumW'(order_q[g]))
                            > new_prio);
    assign cell_match[g] = cell_valid[g] && (order_q[g] == v_idx);
    if (g == 0) begin : g_first
      assign prev_e[g] = order_q[g];
    end else begin : g_mid
      assign prev_e[g] = order_q[g-1];
    end
    if (g == N - 1) begin : g_last
      assign next_e[g] = order_q[g];
    end else begin : g_body
      assign next_e[g] = order_q[g+1];
    end
  end

  assign ins_mask  = prefix_or(cell_ge);
  assign ins_after = ins_mask << 1;
  assign ins_at    = ins_mask & ~ins_after;
  assign rem_mask  = prefix_or(cell_match);

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_clear = 1'b0;
    case (op_q.action)
      pipq_pkg::ACT_PUSH:  do_push  = irq_ok && !is_pending && (len_q < pipq_pkg::LenW'(N));
      pipq_pkg::ACT_POP:   do_pop   = (len_q != '0);
      pipq_pkg::ACT_CLEAR: do_clear = irq_ok && is_pending;
      default: ;
    endcase
  end

  assign do_down   = do_pop || (do_clear && (cell_match != '0));
  assign down_mask = do_pop ? '1 : rem_mask;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      order_d[i] = order_q[i];
      if (do_push) begin
        if (ins_at[i]) order_d[i] = v_idx;
        else if (ins_after[i]) order_d[i] = prev_e[i];
      end else if (do_down && down_mask[i]) begin
        order_d[i] = next_e[i];
      end
    end
  end

  always_comb begin
    len_d  = len_q;
    bits_d = bits_q;
    res_d  = '0;
    if (do_push) begin
      len_d         = len_q + 1'b1;
      bits_d[v_idx] = 1'b1;
    end
    if (do_down) begin
      len_d = len_q - 1'b1;
    end
    if (do_pop) begin
      bits_d[order_q[0]] = 1'b0;
      res_d.popped_valid = 1'b1;
      res_d.popped_irq   = pipq_pkg::IrqNumW'(order_q[0]);
    end
    if (do_clear) begin
      bits_d[v_idx] = 1'b0;
    end
    res_d.pending_count = pipq_pkg::CountW'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      bits_q <= '0;
    end else if (cmd_i.exec) begin
      len_q  <= len_d;
      bits_q <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) op_q <= item_i;
    if (cmd_i.exec) begin
      res_q   <= res_d;
      order_q <= order_d;
    end
  end

  assign result_o = res_q;

  `PIPQ_ASSERT(a_bits_match_len, clk_i, rst_ni, ($countones(bits_q) == 32'(len_q)), "pending bits disagree with list length")
  `PIPQ_ASSERT(a_len_bound, clk_i, rst_ni, (32'(len_q) <= N), "list length beyond vector count")
  `PIPQ_ASSERT(a_idle_holds, clk_i, rst_ni, !cmd_i.exec |=> ($stable(len_q) && $stable(bits_q)), "list changed outside execute step")

endmodule

/* rtl/core/interrupt_pending_priority_queue_unit.sv */
`timescale 1ns / 1ps
// result strobe done_o is registered from the execute state, which the start transfer enters
// a new start is taken only while busy is low; busy is high for the single execute cycle
// the execute cycle runs the compare-and-shift cell chain over all 32 list entries
// result_o holds until the next execute step; done_o is high for one cycle only; the receiver cannot stall
// reset (rst_ni low, asynchronous) empties the list and zeroes both priority tables

module interrupt_pending_priority_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pipq_pkg::in_item_t          item_i,
  output pipq_pkg::result_t           result_o,
  output logic                        done_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pipq_pkg::AddrW-1:0]  paddr,
  input  logic [pipq_pkg::TableW-1:0] pwdata,
  output logic [pipq_pkg::TableW-1:0] prdata,
  output logic                        pready
);

  pipq_pkg::prio_tables_t tables;
  pipq_pkg::dp_cmd_t      cmd;

  pipq_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .tables_o (tables)
  );

  pipq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  pipq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .tables_i (tables),
    .result_o (result_o)
  );

endmodule
